FILE: src/ufrs_pkg.sv
// Shared types and constants for the union-find engine.
// No dependencies; used by ufrs_reduce and union_find_rank_size.
package ufrs_pkg;

    localparam int NODES_DEF = 1024;    // default node table depth
    localparam int NODE_W    = 10;      // width of node fields on the ports
    localparam int RANK_W    = 4;
    localparam int SIZE_W    = 11;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // One request: the two nodes to connect
    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_request;

    // One result: roots and sizes seen before the merge
    typedef struct packed {
        logic              merged;
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic [SIZE_W-1:0] size_a;
        logic [SIZE_W-1:0] size_b;
    } t_result;

endpackage

FILE: src/ufrs_reduce.sv
// Reduces two node indexes modulo NODES by reciprocal multiplication: quotients are registered first, then remainders.
// Depends on ufrs_pkg.
module ufrs_reduce #(
    parameter int NODES = ufrs_pkg::NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ufrs_pkg::NODE_W-1:0] i_a,
    input  logic [ufrs_pkg::NODE_W-1:0] i_b,
    output logic                        o_done,
    output logic [ufrs_pkg::NODE_W-1:0] o_a,
    output logic [ufrs_pkg::NODE_W-1:0] o_b
);
    import ufrs_pkg::*;

    // (x * RecipM) >> ShiftS is exactly x / NODES for every NODE_W-bit x
    localparam int ShiftS = NODE_W + $clog2(NODES);
    localparam logic [31:0] RecipM =
        32'(((64'd1 << ShiftS) + 64'(NODES) - 64'd1) / 64'(NODES));
    localparam logic [31:0] NodesWide = 32'(NODES);

    logic              r_run;
    logic              r_done;
    logic [NODE_W-1:0] r_xa;
    logic [NODE_W-1:0] r_xb;
    logic [NODE_W-1:0] r_qa;
    logic [NODE_W-1:0] r_qb;
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic [31:0]       prod_a;
    logic [31:0]       prod_b;
    logic [31:0]       rem_a;
    logic [31:0]       rem_b;

    // quotient from the incoming indexes
    assign prod_a = 32'(i_a) * RecipM;
    assign prod_b = 32'(i_b) * RecipM;

    // remainder from the registered quotient
    assign rem_a = 32'(r_xa) - 32'(r_qa) * NodesWide;
    assign rem_b = 32'(r_xb) - 32'(r_qb) * NodesWide;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= i_start;
            r_done <= r_run;
        end
    end

    // on start: capture indexes and quotients
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_xa <= i_a;
            r_xb <= i_b;
            r_qa <= NODE_W'(prod_a >> ShiftS);
            r_qb <= NODE_W'(prod_b >> ShiftS);
        end
    end

    // then the remainders, from the registered quotients
    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_a <= NODE_W'(rem_a);
            r_b <= NODE_W'(rem_b);
        end
    end

    assign o_done = r_done;
    assign o_a    = r_a;
    assign o_b    = r_b;

    a_done_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (32'(r_a) < NodesWide) && (32'(r_b) < NodesWide))
        else $error("reduced index not below NODES");
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run))
        else $error("done without a reduction in progress");
    a_run_excl_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !r_done)
        else $error("done while still reducing");

endmodule

FILE: src/union_find_rank_size.sv
// Union-find engine top level: node table memory, find/compress/link sequencer.
// Depends on ufrs_pkg and ufrs_reduce.
//
// Usage: after reset the block holds busy high while it sweeps the node table
// (every node its own root, rank 0, size 1). A request is taken when start is
// high and busy is low. Both node indexes are first reduced modulo NODES, then
// each root is found by walking parent links and the walked path is pointed
// straight at the root. Each memory access is one link: the block holds one
// table with one write and one read per cycle, so each node is first walked up
// to its root and its path is then compressed. On a merge, busy stays high until
// the new root's rank and size are written. The result appears on o_res for
// exactly one cycle with o_valid high and cannot be held off: the receiver
// must take it then.
module union_find_rank_size #(
    parameter int NODES = ufrs_pkg::NODES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ufrs_pkg::t_request i_req,
    output logic               busy,
    output logic               o_valid,
    output ufrs_pkg::t_result  o_res
);
    import ufrs_pkg::*;

    localparam int IdxW = $clog2(NODES);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NODES - 1);

    typedef struct packed {
        logic [IdxW-1:0]   parent;
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_REDUCE = 8'b0000_0100,
        S_ISSUE  = 8'b0000_1000,
        S_FIND   = 8'b0001_0000,
        S_COMP   = 8'b0010_0000,
        S_LINK   = 8'b0100_0000,
        S_GROW   = 8'b1000_0000
    } t_state;

    // node table
    t_entry mem [NODES];
    t_entry r_rd;

    logic            mem_we;
    logic [IdxW-1:0] mem_waddr;
    t_entry          mem_wdata;
    logic            mem_re;
    logic [IdxW-1:0] mem_raddr;

    // sequencer state
    t_state            r_state,    n_state;
    logic [IdxW-1:0]   r_clr,      n_clr;
    logic              r_side,     n_side;
    logic [IdxW-1:0]   r_start,    n_start;
    logic [IdxW-1:0]   r_start_b,  n_start_b;
    logic [IdxW-1:0]   r_cur,      n_cur;
    logic [IdxW-1:0]   r_root,     n_root;
    logic [IdxW-1:0]   r_root_a,   n_root_a;
    logic [IdxW-1:0]   r_root_b,   n_root_b;
    logic [RANK_W-1:0] r_rank_a,   n_rank_a;
    logic [RANK_W-1:0] r_rank_b,   n_rank_b;
    logic [SIZE_W-1:0] r_size_a,   n_size_a;
    logic [SIZE_W-1:0] r_size_b,   n_size_b;
    logic [IdxW-1:0]   r_win,      n_win;
    logic [RANK_W-1:0] r_win_rank, n_win_rank;
    logic [SIZE_W-1:0] r_sum,      n_sum;
    logic              r_valid,    n_valid;
    t_result           r_res,      n_res;

    // modulo reduction of incoming indexes
    logic              red_start;
    logic              red_done;
    logic [NODE_W-1:0] red_a;
    logic [NODE_W-1:0] red_b;

    ufrs_reduce #(
        .NODES (NODES)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_a     (i_req.node_a),
        .i_b     (i_req.node_b),
        .o_done  (red_done),
        .o_a     (red_a),
        .o_b     (red_b)
    );

    // link decision helpers
    logic              a_wins;
    logic [SIZE_W:0]   sum_full;
    logic [SIZE_W-1:0] sum_sat;

    assign a_wins   = !(r_rank_a < r_rank_b);
    assign sum_full = {1'b0, r_size_a} + {1'b0, r_size_b};
    assign sum_sat  = sum_full[SIZE_W] ? SIZE_MAX : sum_full[SIZE_W-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_side     = r_side;
        n_start    = r_start;
        n_start_b  = r_start_b;
        n_cur      = r_cur;
        n_root     = r_root;
        n_root_a   = r_root_a;
        n_root_b   = r_root_b;
        n_rank_a   = r_rank_a;
        n_rank_b   = r_rank_b;
        n_size_a   = r_size_a;
        n_size_b   = r_size_b;
        n_win      = r_win;
        n_win_rank = r_win_rank;
        n_sum      = r_sum;
        n_valid    = 1'b0;
        n_res      = r_res;
        red_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_cur;
        mem_wdata  = r_rd;
        mem_re     = 1'b0;
        mem_raddr  = r_cur;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '{parent: r_clr, rank: '0, size: SIZE_W'(1)};
                n_clr     = r_clr + 1'b1;
                if (r_clr == LastIdx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    red_start = 1'b1;
                    n_state   = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (red_done) begin
                    n_start   = IdxW'(red_a);
                    n_start_b = IdxW'(red_b);
                    n_side    = 1'b0;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                mem_re    = 1'b1;
                mem_raddr = r_start;
                n_cur     = r_start;
                n_state   = S_FIND;
            end
            S_FIND: begin
                if (r_rd.parent == r_cur) begin
                    // root reached: note it, then compress from the start node if it is not the root
                    n_root = r_cur;
                    if (!r_side) begin
                        n_root_a = r_cur;
                        n_rank_a = r_rd.rank;
                        n_size_a = r_rd.size;
                    end else begin
                        n_root_b = r_cur;
                        n_rank_b = r_rd.rank;
                        n_size_b = r_rd.size;
                    end
                    if (r_start != r_cur) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_start;
                        n_cur     = r_start;
                        n_state   = S_COMP;
                    end else if (!r_side) begin
                        n_side  = 1'b1;
                        n_start = r_start_b;
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd.parent;
                    n_cur     = r_rd.parent;
                end
            end
            S_COMP: begin
                // point this node at the root, keep its rank and size
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = '{parent: r_root, rank: r_rd.rank, size: r_rd.size};
                if (r_rd.parent == r_root) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_start = r_start_b;
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rd.parent;
                    n_cur     = r_rd.parent;
                end
            end
            S_LINK: begin
                n_valid      = 1'b1;
                n_res.root_a = NODE_W'(r_root_a);
                n_res.root_b = NODE_W'(r_root_b);
                n_res.size_a = r_size_a;
                n_res.size_b = r_size_b;
                if (r_root_a == r_root_b) begin
                    n_res.merged = 1'b0;
                    n_state      = S_IDLE;
                end else begin
                    // hang the loser under the winner
                    n_res.merged = 1'b1;
                    mem_we       = 1'b1;
                    if (a_wins) begin
                        mem_waddr  = r_root_b;
                        mem_wdata  = '{parent: r_root_a, rank: r_rank_b, size: r_size_b};
                        n_win      = r_root_a;
                        n_win_rank = r_rank_a;
                        if (r_rank_a == r_rank_b && r_rank_a != RANK_MAX) begin
                            n_win_rank = r_rank_a + 1'b1;
                        end
                    end else begin
                        mem_waddr  = r_root_a;
                        mem_wdata  = '{parent: r_root_b, rank: r_rank_a, size: r_size_a};
                        n_win      = r_root_b;
                        n_win_rank = r_rank_b;
                    end
                    n_sum   = sum_sat;
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                mem_we    = 1'b1;
                mem_waddr = r_win;
                mem_wdata = '{parent: r_win, rank: r_win_rank, size: r_sum};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_side  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_side  <= n_side;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_start_b  <= n_start_b;
        r_cur      <= n_cur;
        r_root     <= n_root;
        r_root_a   <= n_root_a;
        r_root_b   <= n_root_b;
        r_rank_a   <= n_rank_a;
        r_rank_b   <= n_rank_b;
        r_size_a   <= n_size_a;
        r_size_b   <= n_size_b;
        r_win      <= n_win;
        r_win_rank <= n_win_rank;
        r_sum      <= n_sum;
        r_res      <= n_res;
    end

    // table write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // table read port, registered
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[mem_raddr];
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_merge_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.merged == (r_res.root_a != r_res.root_b)
                     || NODES > (1 << NODE_W)))
        else $error("merged flag disagrees with roots");
    a_same_set_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.merged) |-> (r_res.size_a == r_res.size_b))
        else $error("same set reported with different sizes");
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(NODES)))
        else $error("table write beyond NODES");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for union_find_rank_size: a directed table, then random merge phases.
// Expected results come from a disjoint-set predictor held in this file.
// Depends on ufrs_pkg and the union_find_rank_size RTL.
module testbench;

    import ufrs_pkg::*;

    localparam int N_NODES     = NODES_DEF;
    localparam int RANDOM_ITEMS = 410;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 64;

    // One row of the directed stimulus table
    typedef struct {
        t_request req;
        bit       typed;
        t_result  res;
    } t_stim_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    t_request i_req;
    logic     busy;
    logic     o_valid;
    t_result  o_res;

    // Predictor copy of the node tables
    int unsigned     dsu_parent [N_NODES];
    logic [RANK_W-1:0] dsu_rank [N_NODES];
    int unsigned     dsu_size   [N_NODES];

    t_result   pending_results [$];
    t_stim_row directed_rows [$];
    int        mismatch_count = 0;
    int        sent_count = 0;
    int        cycle_count = 0;
    bit        burst_mode = 1'b0;

    union_find_rank_size u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    // Find with full path compression
    function automatic int unsigned find_root(int unsigned start_node);
        int unsigned root;
        int unsigned cur;
        int unsigned nxt;
        int unsigned guard;
        root = start_node;
        guard = 0;
        while (dsu_parent[root] != root && guard < N_NODES) begin
            root = dsu_parent[root] % N_NODES;
            guard++;
        end
        cur = start_node;
        guard = 0;
        while (cur != root && guard < N_NODES) begin
            nxt = dsu_parent[cur] % N_NODES;
            dsu_parent[cur] = root;
            cur = nxt;
            guard++;
        end
        return root;
    endfunction

    // Union by rank; returns the result the block should report
    function automatic t_result union_nodes(t_request req);
        t_result     res;
        int unsigned na;
        int unsigned nb;
        int unsigned ra;
        int unsigned rb;
        int unsigned sa;
        int unsigned sb;
        int unsigned win;
        int unsigned lose;
        int unsigned sum;
        na = int'(req.node_a) % N_NODES;
        nb = int'(req.node_b) % N_NODES;
        ra = find_root(na);
        rb = find_root(nb);
        sa = dsu_size[ra];
        sb = dsu_size[rb];
        res.merged = 1'b0;
        if (ra != rb) begin
            res.merged = 1'b1;
            if (dsu_rank[ra] < dsu_rank[rb]) begin
                win = rb;
                lose = ra;
            end else begin
                win = ra;
                lose = rb;
                if (dsu_rank[ra] == dsu_rank[rb] && dsu_rank[ra] != RANK_MAX)
                    dsu_rank[ra] = dsu_rank[ra] + 1'b1;
            end
            dsu_parent[lose] = win;
            sum = sa + sb;
            dsu_size[win] = (sum > int'(SIZE_MAX)) ? int'(SIZE_MAX) : sum;
        end
        res.root_a = NODE_W'(ra);
        res.root_b = NODE_W'(rb);
        res.size_a = SIZE_W'(sa);
        res.size_b = SIZE_W'(sb);
        return res;
    endfunction

    // Table rows: with a typed-in result, or left to the predictor
    task automatic add_typed(input int a, input int b, input bit m,
                             input int ra, input int rb, input int sa, input int sb);
        t_stim_row row;
        row.req.node_a = NODE_W'(a);
        row.req.node_b = NODE_W'(b);
        row.typed      = 1'b1;
        row.res.merged = m;
        row.res.root_a = NODE_W'(ra);
        row.res.root_b = NODE_W'(rb);
        row.res.size_a = SIZE_W'(sa);
        row.res.size_b = SIZE_W'(sb);
        directed_rows.push_back(row);
    endtask

    task automatic add_free(input int a, input int b);
        t_stim_row row;
        row.req.node_a = NODE_W'(a);
        row.req.node_b = NODE_W'(b);
        row.typed      = 1'b0;
        row.res        = '0;
        directed_rows.push_back(row);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request, wait for it to be taken, record the expectation
    task automatic send_request(input t_request req, input bit typed, input t_result typed_res);
        t_result expd;
        int      gap;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expd = union_nodes(req);
        if (typed) expd = typed_res;
        pending_results.push_back(expd);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(input int a, input int b);
        t_request req;
        req.node_a = NODE_W'(a);
        req.node_b = NODE_W'(b);
        send_request(req, 1'b0, '0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random pair, one node from each of two node ranges, sides swapped at random
    task automatic send_group_pair(input int lo_a, input int span_a, input int lo_b,
                                   input int span_b);
        int a;
        int b;
        a = lo_a + $urandom_range(0, span_a - 1);
        b = lo_b + $urandom_range(0, span_b - 1);
        if ($urandom_range(0, 1)) send_pair(b, a);
        else send_pair(a, b);
    endtask

    // Result checker: one strobe, one expectation
    always @(posedge i_clk) begin
        t_result expd;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0d] unexpected result: merged=%0d ra=%0d rb=%0d sa=%0d sb=%0d",
                             cycle_count, o_res.merged, o_res.root_a, o_res.root_b,
                             o_res.size_a, o_res.size_b);
            end else begin
                expd = pending_results.pop_front();
                if (o_res.merged !== expd.merged || o_res.root_a !== expd.root_a ||
                    o_res.root_b !== expd.root_b || o_res.size_a !== expd.size_a ||
                    o_res.size_b !== expd.size_b) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"[%0d] result differs: exp merged=%0d ra=%0d rb=%0d ",
                                  "sa=%0d sb=%0d, got merged=%0d ra=%0d rb=%0d sa=%0d sb=%0d"},
                                 cycle_count, expd.merged, expd.root_a, expd.root_b,
                                 expd.size_a, expd.size_b, o_res.merged, o_res.root_a,
                                 o_res.root_b, o_res.size_a, o_res.size_b);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int grp;
        int base;
        int span;
        int g;
        int q;
        int tail;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        for (int k = 0; k < N_NODES; k++) begin
            dsu_parent[k] = k;
            dsu_rank[k]   = '0;
            dsu_size[k]   = 1;
        end

        // Directed table: extremes, same node, same set, rank ties and rank wins
        add_typed(0, 1023, 1'b1, 0, 1023, 1, 1);
        add_typed(5, 5, 1'b0, 5, 5, 1, 1);
        add_typed(1023, 0, 1'b0, 0, 0, 2, 2);
        add_typed(1, 2, 1'b1, 1, 2, 1, 1);
        add_typed(3, 1, 1'b1, 3, 1, 1, 2);
        add_typed(0, 3, 1'b1, 0, 1, 2, 3);
        add_typed(2, 1023, 1'b0, 0, 0, 5, 5);
        add_typed('h2AA, 'h155, 1'b1, 'h2AA, 'h155, 1, 1);
        add_typed('h200, 'h1FF, 1'b1, 'h200, 'h1FF, 1, 1);
        add_typed('h155, 'h2AA, 1'b0, 'h2AA, 'h2AA, 2, 2);
        // build a rank-3 tree, then query its deepest leaf
        add_free(16, 17);
        add_free(18, 19);
        add_free(16, 18);
        add_free(20, 21);
        add_free(22, 23);
        add_free(20, 22);
        add_free(16, 20);
        add_free(23, 19);
        add_free(21, 1023);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        wait_drained();

        // Random phases: hierarchical merges inside a node group, queries, some noise
        while (sent_count < directed_rows.size() + RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: grp = 8;
                1: grp = 16;
                default: grp = 32;
            endcase
            base = $urandom_range(0, N_NODES / grp - 1) * grp;
            for (span = 1; span < grp; span = span * 2) begin
                for (g = 0; g < grp; g = g + 2 * span) begin
                    if ($urandom_range(0, 4) == 0)
                        send_pair($urandom_range(0, N_NODES - 1), $urandom_range(0, N_NODES - 1));
                    send_group_pair(base + g, span, base + g + span, span);
                end
            end
            for (q = 0; q < 6; q++)
                send_group_pair(base, grp, base, grp);
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
        start <= 1'b0;

        // Let the last results arrive
        while (pending_results.size() != 0) @(posedge i_clk);
        for (tail = 0; tail < TAIL_CYCLES; tail++) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
src/ufrs_pkg.sv
src/ufrs_reduce.sv
src/union_find_rank_size.sv
tb/testbench.sv
